// File: rtl/circle_segment_collision_unit_macros.svh
// Assertion macros shared by the circle and segment contact classifier.
`ifndef CIRCLE_SEGMENT_COLLISION_UNIT_MACROS_SVH
`define CIRCLE_SEGMENT_COLLISION_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/csc_pkg.sv
// Types and constants of the circle and segment contact classifier.
package csc_pkg;

    // Contact classes reported on the result channel.
    typedef enum logic [1:0] {
        CONTACT_NONE     = 2'd0,
        CONTACT_FIRST    = 2'd1,
        CONTACT_INTERIOR = 2'd2,
        CONTACT_SECOND   = 2'd3
    } contact_t;

    // Number of register stages from the input transfer to the result register.
    localparam int NUM_STAGES = 7;

    // The result carries the two-bit contact class, padded to one byte.
    localparam int M_TDATA_BITS = 8;

endpackage

// File: rtl/circle_segment_collision_unit.sv
// Pipelined circle against line segment contact classifier, top level.
//
// The block takes one circle (centre C, radius r) and one segment from a first
// endpoint A to a second endpoint B per transfer and returns one two-bit contact
// class per transfer, in order. When the projection of C falls strictly inside
// the segment (AB.AC > 0 and AB.AC < |AB|^2), the result is interior if
// (AB x AC)^2 < r^2 |AB|^2 and none otherwise. Otherwise A is tested
// (|AC|^2 < r^2), then B (|BC|^2 < r^2). All tests are exact integer compares,
// so a zero-length segment falls to the endpoint tests and a zero radius never
// reports contact. The pipeline accepts one transfer every clock cycle while
// the result channel is not stalled, and registers each transfer through seven
// register stages (differences, products, sums, compares and magnitude, split
// partial products of the wide squares, their sums, and the result register).
// Each stage has its own valid bit and moves on whenever the
// stage after it is empty or moving, so a stalled result only holds back the
// stages behind it until the bubbles are used up, and nothing is lost or
// repeated.
`include "circle_segment_collision_unit_macros.svh"

module circle_segment_collision_unit #(
    parameter int COORD_BITS = 12,
    localparam int S_TDATA_BITS = ((7 * COORD_BITS - 1 + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0 up: center_x, center_y, radius, first_x, first_y,
    // second_x, second_y, then zero padding to a whole byte.
    input  logic [S_TDATA_BITS-1:0]          s_tdata,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0 up: contact, then zero padding.
    output logic [csc_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import csc_pkg::*;

    // Field positions within s_tdata.
    localparam int CB     = COORD_BITS;
    localparam int RB     = COORD_BITS - 1;
    localparam int CX_LSB = 0;
    localparam int CY_LSB = CB;
    localparam int R_LSB  = 2 * CB;
    localparam int AX_LSB = 2 * CB + RB;
    localparam int AY_LSB = 3 * CB + RB;
    localparam int BX_LSB = 4 * CB + RB;
    localparam int BY_LSB = 5 * CB + RB;

    // Datapath widths. A coordinate difference needs one bit more than a
    // coordinate; its products stay below 2^(2*CB) in magnitude and their sums
    // below 2^(2*CB+1).
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * CB + 1;
    localparam int SW  = 2 * CB + 2;
    localparam int MW  = 2 * CB + 1;
    localparam int RW2 = 2 * RB;
    localparam int LW  = 2 * MW;

    // Halves used to split the wide squares into narrow partial products.
    localparam int H   = (MW + 1) / 2;
    localparam int HH  = MW - H;
    localparam int G   = (RW2 + 1) / 2;
    localparam int GH  = RW2 - G;
    localparam int QW  = 2 * H;
    localparam int TW  = G + H;

    localparam int NS  = NUM_STAGES;

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic [NS-1:0] en;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;

    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = s_tvalid;
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign s_tready = en[0];

    // ------------------------------------------------------------------
    // Stage 0: coordinate differences.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] abx0_reg, aby0_reg, acx0_reg, acy0_reg, bcx0_reg, bcy0_reg;
    logic signed [DW-1:0] abx0_next, aby0_next, acx0_next, acy0_next, bcx0_next, bcy0_next;
    logic        [RB-1:0] r0_reg, r0_next;

    always_comb begin
        logic signed [CB-1:0] cx, cy, ax, ay, bx, by;
        cx = $signed(s_tdata[CX_LSB +: CB]);
        cy = $signed(s_tdata[CY_LSB +: CB]);
        ax = $signed(s_tdata[AX_LSB +: CB]);
        ay = $signed(s_tdata[AY_LSB +: CB]);
        bx = $signed(s_tdata[BX_LSB +: CB]);
        by = $signed(s_tdata[BY_LSB +: CB]);
        abx0_next = DW'(bx) - DW'(ax);
        aby0_next = DW'(by) - DW'(ay);
        acx0_next = DW'(cx) - DW'(ax);
        acy0_next = DW'(cy) - DW'(ay);
        bcx0_next = DW'(cx) - DW'(bx);
        bcy0_next = DW'(cy) - DW'(by);
        r0_next   = s_tdata[R_LSB +: RB];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            abx0_reg <= abx0_next;
            aby0_reg <= aby0_next;
            acx0_reg <= acx0_next;
            acy0_reg <= acy0_next;
            bcx0_reg <= bcx0_next;
            bcy0_reg <= bcy0_next;
            r0_reg   <= r0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products of differences and the squared radius.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] dxa1_reg, dya1_reg, lxx1_reg, lyy1_reg, cxy1_reg, cyx1_reg;
    logic signed [PW-1:0] acxx1_reg, acyy1_reg, bcxx1_reg, bcyy1_reg;
    logic signed [PW-1:0] dxa1_next, dya1_next, lxx1_next, lyy1_next, cxy1_next, cyx1_next;
    logic signed [PW-1:0] acxx1_next, acyy1_next, bcxx1_next, bcyy1_next;
    logic        [RW2-1:0] r2_1_reg, r2_1_next;

    always_comb begin
        dxa1_next  = PW'(abx0_reg) * PW'(acx0_reg);
        dya1_next  = PW'(aby0_reg) * PW'(acy0_reg);
        lxx1_next  = PW'(abx0_reg) * PW'(abx0_reg);
        lyy1_next  = PW'(aby0_reg) * PW'(aby0_reg);
        cxy1_next  = PW'(abx0_reg) * PW'(acy0_reg);
        cyx1_next  = PW'(aby0_reg) * PW'(acx0_reg);
        acxx1_next = PW'(acx0_reg) * PW'(acx0_reg);
        acyy1_next = PW'(acy0_reg) * PW'(acy0_reg);
        bcxx1_next = PW'(bcx0_reg) * PW'(bcx0_reg);
        bcyy1_next = PW'(bcy0_reg) * PW'(bcy0_reg);
        r2_1_next  = RW2'(r0_reg) * RW2'(r0_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dxa1_reg  <= dxa1_next;
            dya1_reg  <= dya1_next;
            lxx1_reg  <= lxx1_next;
            lyy1_reg  <= lyy1_next;
            cxy1_reg  <= cxy1_next;
            cyx1_reg  <= cyx1_next;
            acxx1_reg <= acxx1_next;
            acyy1_reg <= acyy1_next;
            bcxx1_reg <= bcxx1_next;
            bcyy1_reg <= bcyy1_next;
            r2_1_reg  <= r2_1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot product, squared length, cross product, squared distances.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] dot2_reg, len2_2_reg, cross2_reg, ac2_2_reg, bc2_2_reg;
    logic signed [SW-1:0] dot2_next, len2_2_next, cross2_next, ac2_2_next, bc2_2_next;
    logic        [RW2-1:0] r2_2_reg;

    always_comb begin
        dot2_next   = SW'(dxa1_reg) + SW'(dya1_reg);
        len2_2_next = SW'(lxx1_reg) + SW'(lyy1_reg);
        cross2_next = SW'(cxy1_reg) - SW'(cyx1_reg);
        ac2_2_next  = SW'(acxx1_reg) + SW'(acyy1_reg);
        bc2_2_next  = SW'(bcxx1_reg) + SW'(bcyy1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            dot2_reg   <= dot2_next;
            len2_2_reg <= len2_2_next;
            cross2_reg <= cross2_next;
            ac2_2_reg  <= ac2_2_next;
            bc2_2_reg  <= bc2_2_next;
            r2_2_reg   <= r2_1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: inside and endpoint tests, cross product magnitude.
    // ------------------------------------------------------------------
    logic           inside3_reg, near_a3_reg, near_b3_reg;
    logic           inside3_next, near_a3_next, near_b3_next;
    logic [MW-1:0]  cmag3_reg, cmag3_next;
    logic [MW-1:0]  len3_reg, len3_next;
    logic [RW2-1:0] r2_3_reg;

    always_comb begin
        logic signed [SW-1:0] r2_s;
        logic signed [SW-1:0] cross_abs;
        r2_s         = $signed(SW'(r2_2_reg));
        cross_abs    = cross2_reg[SW-1] ? -cross2_reg : cross2_reg;
        inside3_next = (dot2_reg > 0) && (dot2_reg < len2_2_reg);
        near_a3_next = ac2_2_reg < r2_s;
        near_b3_next = bc2_2_reg < r2_s;
        cmag3_next   = cross_abs[MW-1:0];
        len3_next    = len2_2_reg[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            inside3_reg <= inside3_next;
            near_a3_reg <= near_a3_next;
            near_b3_reg <= near_b3_next;
            cmag3_reg   <= cmag3_next;
            len3_reg    <= len3_next;
            r2_3_reg    <= r2_2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of cross^2 and r^2 * |AB|^2 on split halves.
    // ------------------------------------------------------------------
    logic          inside4_reg, near_a4_reg, near_b4_reg;
    logic [QW-1:0] qll4_reg, qlh4_reg, qhh4_reg;
    logic [QW-1:0] qll4_next, qlh4_next, qhh4_next;
    logic [TW-1:0] tll4_reg, tlh4_reg, thl4_reg, thh4_reg;
    logic [TW-1:0] tll4_next, tlh4_next, thl4_next, thh4_next;

    always_comb begin
        logic [H-1:0]  c_lo, l_lo;
        logic [HH-1:0] c_hi, l_hi;
        logic [G-1:0]  r_lo;
        logic [GH-1:0] r_hi;
        c_lo = cmag3_reg[H-1:0];
        c_hi = cmag3_reg[MW-1:H];
        l_lo = len3_reg[H-1:0];
        l_hi = len3_reg[MW-1:H];
        r_lo = r2_3_reg[G-1:0];
        r_hi = r2_3_reg[RW2-1:G];
        qll4_next = QW'(c_lo) * QW'(c_lo);
        qlh4_next = QW'(c_lo) * QW'(c_hi);
        qhh4_next = QW'(c_hi) * QW'(c_hi);
        tll4_next = TW'(r_lo) * TW'(l_lo);
        tlh4_next = TW'(r_lo) * TW'(l_hi);
        thl4_next = TW'(r_hi) * TW'(l_lo);
        thh4_next = TW'(r_hi) * TW'(l_hi);
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            inside4_reg <= inside3_reg;
            near_a4_reg <= near_a3_reg;
            near_b4_reg <= near_b3_reg;
            qll4_reg    <= qll4_next;
            qlh4_reg    <= qlh4_next;
            qhh4_reg    <= qhh4_next;
            tll4_reg    <= tll4_next;
            tlh4_reg    <= tlh4_next;
            thl4_reg    <= thl4_next;
            thh4_reg    <= thh4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: reassembly of the two wide products.
    // ------------------------------------------------------------------
    logic          inside5_reg, near_a5_reg, near_b5_reg;
    logic [LW-1:0] lhs5_reg, rhs5_reg, lhs5_next, rhs5_next;

    always_comb begin
        lhs5_next = (LW'(qhh4_reg) << (2 * H)) + (LW'(qlh4_reg) << (H + 1))
                  + LW'(qll4_reg);
        rhs5_next = (LW'(thh4_reg) << (G + H)) + (LW'(thl4_reg) << G)
                  + (LW'(tlh4_reg) << H) + LW'(tll4_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            inside5_reg <= inside4_reg;
            near_a5_reg <= near_a4_reg;
            near_b5_reg <= near_b4_reg;
            lhs5_reg    <= lhs5_next;
            rhs5_reg    <= rhs5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final classification into the result register.
    // ------------------------------------------------------------------
    contact_t contact_reg, contact_next;

    always_comb begin
        if (inside5_reg) begin
            contact_next = (lhs5_reg < rhs5_reg) ? CONTACT_INTERIOR : CONTACT_NONE;
        end else if (near_a5_reg) begin
            contact_next = CONTACT_FIRST;
        end else if (near_b5_reg) begin
            contact_next = CONTACT_SECOND;
        end else begin
            contact_next = CONTACT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            contact_reg <= contact_next;
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = M_TDATA_BITS'(contact_reg);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CSC_ASSERT_NXT(a_input_enters, aclk, aresetn, s_tvalid && s_tready, valid_reg[0],
        "accepted input transfer did not reach the first stage")
    `CSC_ASSERT_NXT(a_result_held, aclk, aresetn, valid_reg[NS-1] && !m_tready,
        valid_reg[NS-1] && $stable(contact_reg),
        "stalled result was lost or changed")
    `CSC_ASSERT_NXT(a_interior_needs_inside, aclk, aresetn,
        valid_reg[5] && en[6] && !inside5_reg, contact_reg != CONTACT_INTERIOR,
        "interior contact reported for a projection outside the segment")
    `CSC_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !valid_reg[0], s_tready,
        "input stalled although the first stage is empty")

endmodule
